@@ hdl/mbhw_pkg.sv @@
// Shared types, constants and box type table for the media box header walker.
package mbhw_pkg;

	localparam int unsigned KIND_COUNT = 24;
	localparam int unsigned KIND_W = 5;
	localparam int unsigned HDR_CNT_W = 3;

	localparam logic [HDR_CNT_W-1:0] CNT_LAST_SIZE = 3'd3;
	localparam logic [HDR_CNT_W-1:0] CNT_LAST_HDR = 3'd7;
	localparam logic [31:0] HEADER_BYTES = 32'd8;
	localparam logic [31:0] FTYP_MIN_BODY = 32'd16;

	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 5'd0;
	localparam logic [KIND_W-1:0] KIND_FTYP = 5'd1;

	localparam int unsigned TDATA_W = 104;
	localparam int unsigned TUSER_W = 6;

	typedef logic [31:0] code_table_t [KIND_COUNT];

	localparam code_table_t KNOWN_CODES = '{
		"ftyp", "mdat", "moov", "pnot", "udta", "uuid",
		"moof", "free", "skip", "jP2 ", "wide", "load",
		"ctab", "imap", "matt", "kmat", "clip", "crgn",
		"sync", "chap", "tmcd", "scpt", "ssrc", "PICT"
	};

	typedef struct packed {
		logic              header_valid;
		logic [KIND_W-1:0] box_kind;
		logic [31:0]       box_code;
		logic [31:0]       box_size;
		logic [31:0]       payload_length;
		logic              stream_end;
		logic              ended_mid_box;
	} result_t;

endpackage

@@ hdl/mbhw_classify.sv @@
// Box type classifier: matches a four-character code against the known table.
module mbhw_classify (
	input  logic [31:0]                 code,
	output logic [mbhw_pkg::KIND_W-1:0] kind
);

	always_comb begin
		kind = mbhw_pkg::KIND_UNKNOWN;
		for (int i = 0; i < mbhw_pkg::KIND_COUNT; i++) begin
			if (code == mbhw_pkg::KNOWN_CODES[i]) begin
				kind = kind | mbhw_pkg::KIND_W'(i + 1);
			end
		end
	end

endmodule

@@ hdl/mbhw_walker.sv @@
// Box walker: header/body state, header decode and the result register.
module mbhw_walker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic              advance,
	output logic              out_valid,
	output mbhw_pkg::result_t out_res
);

	logic [mbhw_pkg::HDR_CNT_W-1:0] hdr_cnt_q, hdr_cnt_n;
	logic [31:0] size_q, size_n;
	logic [31:0] code_q, code_n;
	logic [31:0] body_q, body_n;
	logic [31:0] code_full;
	logic [31:0] payload;
	logic [mbhw_pkg::KIND_W-1:0] kind;
	logic hdr_done;
	logic out_valid_q;
	mbhw_pkg::result_t res_q, res_n;

	assign code_full = {code_q[23:0], in_byte};

	mbhw_classify u_classify (
		.code (code_full),
		.kind (kind)
	);

	assign payload = (size_q < mbhw_pkg::HEADER_BYTES) ? 32'd0
		: size_q - mbhw_pkg::HEADER_BYTES;

	always_comb begin
		hdr_cnt_n = hdr_cnt_q;
		size_n = size_q;
		code_n = code_q;
		body_n = body_q;
		hdr_done = 1'b0;
		if (body_q != 32'd0) begin
			body_n = body_q - 32'd1;
		end else if (hdr_cnt_q == mbhw_pkg::CNT_LAST_HDR) begin
			hdr_done = 1'b1;
			hdr_cnt_n = '0;
			size_n = '0;
			code_n = '0;
			if (kind == mbhw_pkg::KIND_FTYP && payload < mbhw_pkg::FTYP_MIN_BODY) begin
				body_n = mbhw_pkg::FTYP_MIN_BODY;
			end else begin
				body_n = payload;
			end
		end else begin
			hdr_cnt_n = hdr_cnt_q + 1'b1;
			if (hdr_cnt_q <= mbhw_pkg::CNT_LAST_SIZE) begin
				size_n = {size_q[23:0], in_byte};
			end else begin
				code_n = code_full;
			end
		end

		res_n = '0;
		if (hdr_done) begin
			res_n.header_valid = 1'b1;
			res_n.box_kind = kind;
			res_n.box_code = code_full;
			res_n.box_size = size_q;
			res_n.payload_length = payload;
		end
		res_n.stream_end = in_last;
		res_n.ended_mid_box = in_last && (hdr_cnt_n != '0 || body_n != 32'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q <= '0;
			size_q <= '0;
			code_q <= '0;
			body_q <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= in_valid && (hdr_done || in_last);
			if (in_valid) begin
				if (in_last) begin
					hdr_cnt_q <= '0;
					size_q <= '0;
					code_q <= '0;
					body_q <= '0;
				end else begin
					hdr_cnt_q <= hdr_cnt_n;
					size_q <= size_n;
					code_q <= code_n;
					body_q <= body_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res = res_q;

endmodule

@@ hdl/media_box_header_walker.sv @@
// Top level of the media box header walker: input register and stream ports.
// A byte passes the input register, then its result is held in the walker's result register.
// Throughput: one byte per cycle; a stalled result holds the byte in the input register.
// Per byte the path is a 24-entry code compare and a 32-bit box length subtract/decrement.
// Reset (arst_n low) clears header count, size/code shift state, body count and valids.
module media_box_header_walker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // [7:0] byte_in
	input  logic                          s_tlast,  // last_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mbhw_pkg::TDATA_W-1:0]  m_tdata,  // [31:0] box_code, [63:32] box_size,
	                                                // [95:64] payload_length,
	                                                // [96] ended_mid_box, [103:97] zero
	output logic [mbhw_pkg::TUSER_W-1:0]  m_tuser,  // [0] header_valid, [5:1] box_kind
	output logic                          m_tlast   // stream_end
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;
	logic advance;
	logic out_valid;
	mbhw_pkg::result_t out_res;

	assign advance = !out_valid || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	mbhw_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_byte   (byte_s1),
		.in_last   (last_s1),
		.advance   (advance),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign m_tvalid = out_valid;
	assign m_tdata = {7'd0, out_res.ended_mid_box, out_res.payload_length,
		out_res.box_size, out_res.box_code};
	assign m_tuser = {out_res.box_kind, out_res.header_valid};
	assign m_tlast = out_res.stream_end;

endmodule

@@ hdl/mbhw_checker.sv @@
// Port-level checker for the media box header walker, with its bind.
module mbhw_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [mbhw_pkg::TDATA_W-1:0] m_tdata,
	input logic [mbhw_pkg::TUSER_W-1:0] m_tuser,
	input logic                         m_tlast
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	a_no_header_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata[95:0] == 96'd0
			&& m_tuser[5:1] == 5'd0)
		else $error("result without header outside stream end or with fields set");

	a_mid_box_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !m_tdata[96])
		else $error("ended_mid_box set away from stream end");

	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[95:64] ==
			((m_tdata[63:32] < 32'd8) ? 32'd0 : m_tdata[63:32] - 32'd8))
		else $error("payload length does not follow box size");

endmodule

bind media_box_header_walker mbhw_checker u_mbhw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

@@ bench/box_walk_checker.sv @@
// Scoreboard for the media box header walker: byte-level predictor and result comparison.
module box_walk_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [7:0]                    s_tdata,
	input  logic                          s_tlast,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [mbhw_pkg::TDATA_W-1:0]  m_tdata,
	input  logic [mbhw_pkg::TUSER_W-1:0]  m_tuser,
	input  logic                          m_tlast,
	output int                            errors,
	output int                            pending,
	output int                            headers_seen,
	output int                            ends_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [3:0]  hdr_bytes;
	logic [31:0] size_acc;
	logic [31:0] code_acc;
	logic [31:0] skip_left;
	mbhw_pkg::result_t expected_q[$];
	int          err_count = 0;
	int          hdr_count = 0;
	int          end_count = 0;

	task automatic report(input string msg);
		if (err_count < 50)
			$display("ERROR %0t ns: %s", $time, msg);
		err_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report($sformatf("%s got %h want %h", name, got, want));
	endtask

	function automatic logic [mbhw_pkg::KIND_W-1:0] kind_of(input logic [31:0] code);
		for (int i = 0; i < mbhw_pkg::KIND_COUNT; i++)
			if (mbhw_pkg::KNOWN_CODES[i] == code)
				return mbhw_pkg::KIND_W'(i + 1);
		return mbhw_pkg::KIND_UNKNOWN;
	endfunction

	task automatic walk_byte(input logic [7:0] b, input logic last);
		mbhw_pkg::result_t r;
		logic    hdr;
		r = '0;
		hdr = 1'b0;
		if (skip_left != 0) begin
			skip_left = skip_left - 32'd1;
		end else begin
			if (hdr_bytes < 4)
				size_acc = {size_acc[23:0], b};
			else
				code_acc = {code_acc[23:0], b};
			hdr_bytes = hdr_bytes + 4'd1;
			if (hdr_bytes >= 8) begin
				hdr = 1'b1;
				r.header_valid = 1'b1;
				r.box_code = code_acc;
				r.box_size = size_acc;
				r.box_kind = kind_of(code_acc);
				r.payload_length = (size_acc < mbhw_pkg::HEADER_BYTES) ? 32'd0
					: size_acc - mbhw_pkg::HEADER_BYTES;
				skip_left = r.payload_length;
				if (r.box_kind == mbhw_pkg::KIND_FTYP && skip_left < mbhw_pkg::FTYP_MIN_BODY)
					skip_left = mbhw_pkg::FTYP_MIN_BODY;
				hdr_bytes = '0;
				size_acc = '0;
				code_acc = '0;
			end
		end
		if (hdr || last) begin
			r.stream_end = last;
			r.ended_mid_box = last && (hdr_bytes != 0 || skip_left != 0);
			expected_q.push_back(r);
		end
		if (last) begin
			hdr_bytes = '0;
			size_acc = '0;
			code_acc = '0;
			skip_left = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mbhw_pkg::result_t want;
		if (!arst_n) begin
			hdr_bytes = '0;
			size_acc = '0;
			code_acc = '0;
			skip_left = '0;
			expected_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					report("result transaction with nothing expected");
				end else begin
					want = expected_q.pop_front();
					check_field("header_valid", 32'(m_tuser[0]), 32'(want.header_valid));
					check_field("box_kind", 32'(m_tuser[5:1]), 32'(want.box_kind));
					check_field("box_code", m_tdata[31:0], want.box_code);
					check_field("box_size", m_tdata[63:32], want.box_size);
					check_field("payload_length", m_tdata[95:64], want.payload_length);
					check_field("ended_mid_box", 32'(m_tdata[96]), 32'(want.ended_mid_box));
					check_field("tdata pad", 32'(m_tdata[103:97]), 32'd0);
					check_field("stream_end", 32'(m_tlast), 32'(want.stream_end));
					if (want.header_valid)
						hdr_count++;
					if (want.stream_end)
						end_count++;
				end
			end
			if (s_tvalid && s_tready)
				walk_byte(s_tdata, s_tlast);
		end
		errors <= err_count;
		pending <= expected_q.size();
		headers_seen <= hdr_count;
		ends_seen <= end_count;
	end

endmodule

@@ bench/testbench.sv @@
// Top of the media box header walker bench: clock, reset, byte stream stimulus and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] FTYP_CODE = "ftyp";
	localparam int          TARGET_BYTES = 1200;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic [7:0]                    s_tdata = '0;
	logic                          s_tlast = 1'b0;
	logic                          m_tready = 1'b0;
	logic                          s_tready;
	logic                          m_tvalid;
	logic [mbhw_pkg::TDATA_W-1:0]  m_tdata;
	logic [mbhw_pkg::TUSER_W-1:0]  m_tuser;
	logic                          m_tlast;

	int errors;
	int pending;
	int headers_seen;
	int ends_seen;
	int idle_pct = 11;
	int bytes_sent = 0;
	int streams_sent = 0;

	media_box_header_walker DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	box_walk_checker walk_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.errors       (errors),
		.pending      (pending),
		.headers_seen (headers_seen),
		.ends_seen    (ends_seen)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			m_tready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	initial begin
		#3_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do
			@(posedge clk);
		while (!s_tready);
		bytes_sent++;
	endtask

	task automatic send_stream(ref logic [7:0] q[$]);
		for (int i = 0; i < q.size(); i++)
			send_byte(q[i], i == q.size() - 1);
		streams_sent++;
	endtask

	task automatic add_box(ref logic [7:0] q[$], input logic [31:0] code, input logic [31:0] size,
			input int body_cap);
		longint skip;
		longint n;
		skip = (size < mbhw_pkg::HEADER_BYTES) ? 0 : longint'(size) - mbhw_pkg::HEADER_BYTES;
		if (code == FTYP_CODE && skip < mbhw_pkg::FTYP_MIN_BODY)
			skip = mbhw_pkg::FTYP_MIN_BODY;
		n = (skip < body_cap) ? skip : body_cap;
		for (int i = 3; i >= 0; i--)
			q.push_back(size[8*i +: 8]);
		for (int i = 3; i >= 0; i--)
			q.push_back(code[8*i +: 8]);
		for (longint i = 0; i < n; i++)
			q.push_back(8'($urandom_range(0, 255)));
	endtask

	initial begin
		logic [7:0]  q[$];
		logic [31:0] code;
		logic [31:0] size;
		int          nbox;
		int          cut;
		int          roll;
		int          waited;
		bit          truncated;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		q = {8'h00};
		send_stream(q);
		q = {};
		add_box(q, "free", 32'd0, 0);
		send_stream(q);
		q = {};
		add_box(q, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
		send_stream(q);
		q = {};
		add_box(q, "mdat", 32'd9, 9);
		send_stream(q);

		while (bytes_sent < TARGET_BYTES) begin
			idle_pct = (bytes_sent >= 400 && bytes_sent < 700) ? 0 : 11;
			q = {};
			truncated = 1'b0;
			if ($urandom_range(0, 99) < 10) begin
				repeat ($urandom_range(1, 30))
					q.push_back(8'($urandom_range(0, 255)));
			end else begin
				nbox = $urandom_range(1, 5);
				for (int k = 0; k < nbox && !truncated; k++) begin
					roll = $urandom_range(0, 99);
					if (roll < 15)
						code = FTYP_CODE;
					else if (roll < 80)
						code = mbhw_pkg::KNOWN_CODES[$urandom_range(0, mbhw_pkg::KIND_COUNT - 1)];
					else
						code = $urandom;
					roll = $urandom_range(0, 99);
					if (roll < 15) begin
						size = $urandom_range(0, 7);
					end else if (roll < 92) begin
						size = $urandom_range(8, 48);
					end else begin
						size = $urandom | 32'h0100_0000;
						truncated = 1'b1;
					end
					add_box(q, code, size, truncated ? $urandom_range(0, 20) : 64);
				end
				if (!truncated && $urandom_range(0, 3) == 0) begin
					cut = $urandom_range(1, q.size());
					q = q[0:cut-1];
				end
			end
			send_stream(q);
		end
		s_tvalid <= 1'b0;
		idle_pct = 11;

		@(posedge clk);
		waited = 0;
		while (pending != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);

		$display("Walked %0d bytes in %0d streams: %0d box headers and %0d stream ends checked.",
			bytes_sent, streams_sent, headers_seen, ends_seen);
		if (errors == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d results never arrived", errors, pending);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/mbhw_pkg.sv
hdl/mbhw_classify.sv
hdl/mbhw_walker.sv
hdl/media_box_header_walker.sv
hdl/mbhw_checker.sv
bench/box_walk_checker.sv
bench/testbench.sv
